@@ sv/tcw_pkg.sv @@
// shared constants, types and screen geometry of the text console writer
package tcw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLS * ROWS;

    // field widths fixed by the request and response formats
    localparam int IdxW     = 11;
    localparam int DataW    = 16;

    localparam int ColW     = $clog2(COLS);
    localparam int RowW     = $clog2(ROWS);
    localparam int AddrW    = $clog2(CELLS);

    // row of a cell index by reciprocal multiply, exact for every IdxW-bit index
    localparam int DivShift = IdxW + $clog2(COLS);
    localparam int DivMul   = (2 ** DivShift + COLS - 1) / COLS;
    localparam int DivMulW  = IdxW + 1;
    localparam int ProdW    = IdxW + DivMulW;

    localparam logic [DataW-1:0] BlankCell   = 16'h0720;
    localparam logic [7:0]       DefaultAttr = 8'h07;
    localparam logic [7:0]       ChSpace     = 8'h20;
    localparam logic [7:0]       ChBs        = 8'h08;
    localparam logic [7:0]       ChTab       = 8'h09;
    localparam logic [7:0]       ChLf        = 8'h0a;
    localparam logic [7:0]       ChCr        = 8'h0d;
    localparam logic [2:0]       TabSpaces   = 3'd5;

    localparam logic ReqPut  = 1'b0;
    localparam logic ReqRead = 1'b1;

    typedef struct packed {
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
    } t_rowcol;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [AddrW-1:0] addr;
        logic [DataW-1:0] wdata;
    } t_ram_req;

endpackage

@@ sv/tcw_if.sv @@
// request and response channel interfaces
interface tcw_req_if;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [tcw_pkg::DataW-1:0] char_attr;
    logic [tcw_pkg::IdxW-1:0]  cell_index;

    modport source (output valid, output req_type, output char_attr, output cell_index,
                    input ready);
    modport sink   (input valid, input req_type, input char_attr, input cell_index,
                    output ready);
endinterface

interface tcw_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [tcw_pkg::IdxW-1:0]  cursor_pos;
    logic [tcw_pkg::DataW-1:0] cell_data;

    modport source (output valid, output cursor_pos, output cell_data, input ready);
    modport sink   (input valid, input cursor_pos, input cell_data, output ready);
endinterface

@@ sv/tcw_cell_ram.sv @@
// single-port screen cell memory with registered read data
module tcw_cell_ram (
    input  logic                       i_clk,
    input  tcw_pkg::t_ram_req          i_req,
    output logic [tcw_pkg::DataW-1:0]  o_rdata
);

    logic [tcw_pkg::DataW-1:0] mem [tcw_pkg::CELLS];
    logic [tcw_pkg::DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tcw_idx_split.sv @@
// two-stage split of a linear cell index into row and column
module tcw_idx_split (
    input  logic                      i_clk,
    input  logic [tcw_pkg::IdxW-1:0]  i_idx,
    output tcw_pkg::t_rowcol          o_rc
);

    logic [tcw_pkg::ProdW-1:0] prod;
    logic [tcw_pkg::IdxW-1:0]  r_q;
    logic [tcw_pkg::IdxW-1:0]  r_idx;
    logic [tcw_pkg::IdxW-1:0]  qc;
    tcw_pkg::t_rowcol          r_rc;

    assign prod = tcw_pkg::ProdW'(i_idx) * tcw_pkg::ProdW'(tcw_pkg::DivMul);
    assign qc   = r_q * tcw_pkg::IdxW'(tcw_pkg::COLS);

    always_ff @(posedge i_clk) begin
        r_q    <= tcw_pkg::IdxW'(prod >> tcw_pkg::DivShift);
        r_idx  <= i_idx;
        // only meaningful for in-range indexes, where the quotient fits a row
        r_rc.row <= r_q[tcw_pkg::RowW-1:0];
        r_rc.col <= tcw_pkg::ColW'(r_idx - qc);
    end

    assign o_rc = r_rc;

endmodule

@@ sv/text_console_writer.sv @@
// text console writer top level: request sequencer, cursor, row mapping and output register
//
// Keeps a COLS x ROWS grid of 16-bit cells (character low, attribute high) in one
// single-port memory treated as a ring of rows: a scroll only moves the top-row pointer
// and marks the row that comes into view as blank. Each row has a valid bit, cleared at
// reset; a row that is not valid reads as 0x0720, and the first write into it first
// sweeps the row with blanks, one cell a cycle. So there is no clearing pass after
// reset and requests are taken right away. Requests are handled one at a time by the
// sequencer: a read goes through the row/column split, row mapping, memory read, data
// capture and output register, and skips the memory read and data capture when the
// row is still blank; an out-of-range read, newline, carriage return or backspace at
// cell 0 goes straight to the response; a plain character or backspace writes one cell
// and a tab five, each after its row mapping, plus a row sweep for each row that a write
// finds blank. A new request is accepted while the previous response still waits.
module text_console_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_req_if.sink    i_req,
    tcw_rsp_if.source  o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_PROW,
        S_RADDR,
        S_RDATA,
        S_WCHK,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state                      r_state;
    logic [tcw_pkg::RowW-1:0]    r_row;
    logic [tcw_pkg::ColW-1:0]    r_col;
    logic [tcw_pkg::RowW-1:0]    r_base;
    logic [tcw_pkg::ROWS-1:0]    r_row_valid;
    logic                        r_is_read;
    logic [tcw_pkg::IdxW-1:0]    r_idx;
    logic [tcw_pkg::DataW-1:0]   r_wdata;
    logic                        r_advance;
    logic [2:0]                  r_left;
    logic [tcw_pkg::RowW-1:0]    r_prow;
    logic [tcw_pkg::ColW-1:0]    r_pcol;
    logic [tcw_pkg::ColW-1:0]    r_sweep;
    logic [tcw_pkg::DataW-1:0]   r_data;
    logic                        r_out_valid;
    logic [tcw_pkg::IdxW-1:0]    r_out_pos;
    logic [tcw_pkg::DataW-1:0]   r_out_data;

    logic [tcw_pkg::DataW-1:0]   w_ca;
    tcw_pkg::t_rowcol            w_rc;
    logic [tcw_pkg::RowW-1:0]    w_src_row;
    logic [tcw_pkg::ColW-1:0]    w_src_col;
    logic [tcw_pkg::RowW:0]      w_sum;
    logic [tcw_pkg::RowW-1:0]    n_prow;
    logic [tcw_pkg::RowW-1:0]    n_base;
    logic [tcw_pkg::IdxW-1:0]    w_cursor_pos;
    logic                        w_prow_valid;
    logic                        w_out_free;
    tcw_pkg::t_ram_req           w_ram;
    logic [tcw_pkg::DataW-1:0]   w_rdata;

    // a character with no attribute gets the default grey
    assign w_ca = (i_req.char_attr[15:8] == 8'h00) ?
                  {tcw_pkg::DefaultAttr, i_req.char_attr[7:0]} : i_req.char_attr;

    tcw_idx_split u_split (
        .i_clk (i_clk),
        .i_idx (r_idx),
        .o_rc  (w_rc)
    );

    // logical row to physical row of the ring
    assign w_src_row = r_is_read ? w_rc.row : r_row;
    assign w_src_col = r_is_read ? w_rc.col : r_col;
    assign w_sum     = (tcw_pkg::RowW + 1)'(w_src_row) + (tcw_pkg::RowW + 1)'(r_base);
    assign n_prow    = (w_sum >= (tcw_pkg::RowW + 1)'(tcw_pkg::ROWS)) ?
                       tcw_pkg::RowW'(w_sum - (tcw_pkg::RowW + 1)'(tcw_pkg::ROWS)) :
                       tcw_pkg::RowW'(w_sum);
    assign n_base    = (r_base == tcw_pkg::RowW'(tcw_pkg::ROWS - 1)) ?
                       '0 : r_base + tcw_pkg::RowW'(1);

    assign w_cursor_pos = tcw_pkg::IdxW'(tcw_pkg::IdxW'(r_row) * tcw_pkg::IdxW'(tcw_pkg::COLS))
                        + tcw_pkg::IdxW'(r_col);
    assign w_prow_valid = r_row_valid[r_prow];
    assign w_out_free   = !r_out_valid || o_rsp.ready;

    always_comb begin
        w_ram.we    = ((r_state == S_WCHK) && w_prow_valid) || (r_state == S_SWEEP);
        w_ram.re    = (r_state == S_RADDR) && w_prow_valid;
        w_ram.addr  = tcw_pkg::AddrW'(tcw_pkg::AddrW'(r_prow) * tcw_pkg::AddrW'(tcw_pkg::COLS))
                    + tcw_pkg::AddrW'((r_state == S_SWEEP) ? r_sweep : r_pcol);
        w_ram.wdata = (r_state == S_SWEEP) ? tcw_pkg::BlankCell : r_wdata;
    end

    tcw_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_sweep     <= '0;
        end else begin
            // a new response takes the slot as the old one leaves
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_is_read <= i_req.req_type;
                        r_idx     <= i_req.cell_index;
                        r_data    <= '0;
                        if (i_req.req_type == tcw_pkg::ReqRead) begin
                            if (i_req.cell_index >= tcw_pkg::IdxW'(tcw_pkg::CELLS)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIV1;
                            end
                        end else begin
                            case (w_ca[7:0])
                                tcw_pkg::ChBs: begin
                                    if (r_row == '0 && r_col == '0) begin
                                        r_state <= S_DONE;
                                    end else begin
                                        if (r_col == '0) begin
                                            r_col <= tcw_pkg::ColW'(tcw_pkg::COLS - 1);
                                            r_row <= r_row - tcw_pkg::RowW'(1);
                                        end else begin
                                            r_col <= r_col - tcw_pkg::ColW'(1);
                                        end
                                        r_wdata   <= {w_ca[15:8], tcw_pkg::ChSpace};
                                        r_advance <= 1'b0;
                                        r_left    <= 3'd1;
                                        r_state   <= S_PROW;
                                    end
                                end
                                tcw_pkg::ChLf: begin
                                    r_col <= '0;
                                    if (r_row == tcw_pkg::RowW'(tcw_pkg::ROWS - 1)) begin
                                        r_base              <= n_base;
                                        r_row_valid[r_base] <= 1'b0;
                                    end else begin
                                        r_row <= r_row + tcw_pkg::RowW'(1);
                                    end
                                    r_state <= S_DONE;
                                end
                                tcw_pkg::ChCr: begin
                                    r_col   <= '0;
                                    r_state <= S_DONE;
                                end
                                tcw_pkg::ChTab: begin
                                    r_wdata   <= tcw_pkg::BlankCell;
                                    r_advance <= 1'b1;
                                    r_left    <= tcw_pkg::TabSpaces;
                                    r_state   <= S_PROW;
                                end
                                default: begin
                                    r_wdata   <= w_ca;
                                    r_advance <= 1'b1;
                                    r_left    <= 3'd1;
                                    r_state   <= S_PROW;
                                end
                            endcase
                        end
                    end
                end
                S_DIV1: begin
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_state <= S_PROW;
                end
                S_PROW: begin
                    r_prow  <= n_prow;
                    r_pcol  <= w_src_col;
                    r_state <= r_is_read ? S_RADDR : S_WCHK;
                end
                S_RADDR: begin
                    if (w_prow_valid) begin
                        r_state <= S_RDATA;
                    end else begin
                        r_data  <= tcw_pkg::BlankCell;
                        r_state <= S_DONE;
                    end
                end
                S_RDATA: begin
                    r_data  <= w_rdata;
                    r_state <= S_DONE;
                end
                S_WCHK: begin
                    if (!w_prow_valid) begin
                        r_sweep <= '0;
                        r_state <= S_SWEEP;
                    end else begin
                        if (r_advance) begin
                            if (r_col == tcw_pkg::ColW'(tcw_pkg::COLS - 1)) begin
                                r_col <= '0;
                                if (r_row == tcw_pkg::RowW'(tcw_pkg::ROWS - 1)) begin
                                    r_base              <= n_base;
                                    r_row_valid[r_base] <= 1'b0;
                                end else begin
                                    r_row <= r_row + tcw_pkg::RowW'(1);
                                end
                            end else begin
                                r_col <= r_col + tcw_pkg::ColW'(1);
                            end
                        end
                        r_left  <= r_left - 3'd1;
                        r_state <= (r_left == 3'd1) ? S_DONE : S_PROW;
                    end
                end
                S_SWEEP: begin
                    r_sweep <= r_sweep + tcw_pkg::ColW'(1);
                    if (r_sweep == tcw_pkg::ColW'(tcw_pkg::COLS - 1)) begin
                        r_row_valid[r_prow] <= 1'b1;
                        r_state             <= S_WCHK;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_pos   <= w_cursor_pos;
                        r_out_data  <= r_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_pos = r_out_pos;
    assign o_rsp.cell_data  = r_out_data;

    // cursor never leaves the grid between requests
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row < tcw_pkg::RowW'(tcw_pkg::ROWS - 1) || r_row == tcw_pkg::RowW'(tcw_pkg::ROWS - 1))
        && (r_col < tcw_pkg::ColW'(tcw_pkg::COLS - 1)
            || r_col == tcw_pkg::ColW'(tcw_pkg::COLS - 1)))
        else $error("cursor outside the grid");

    // ring pointer stays on a real row
    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base < tcw_pkg::RowW'(tcw_pkg::ROWS - 1) || r_base == tcw_pkg::RowW'(tcw_pkg::ROWS - 1))
        else $error("top-row pointer out of range");

    // a character write only lands in a row that has been swept
    a_write_swept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCHK && w_ram.we) |-> w_prow_valid)
        else $error("cell write into an unswept row");

    // a finished sweep always marks its row valid
    a_sweep_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_sweep == tcw_pkg::ColW'(tcw_pkg::COLS - 1))
        |=> (r_state == S_WCHK && w_prow_valid))
        else $error("row sweep did not mark the row valid");

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench for the text console writer: put and read requests against a screen model
module tb_top;
    import tcw_pkg::*;

    localparam int CycleLimit = 1_200_000;
    localparam int DrainTail  = 200;
    localparam int MaxIdx     = 2 ** IdxW - 1;

    typedef struct {
        logic [IdxW-1:0]  cursor;
        logic [DataW-1:0] data;
    } screen_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcw_req_if req_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // screen model and the responses it predicts
    logic [DataW-1:0] screen_model [CELLS];
    int               cursor_model;
    screen_result_t   expected_results [$];

    int cycle_count     = 0;
    int results_checked = 0;
    int mismatch_count  = 0;
    int fault_count     = 0;
    int puts_sent       = 0;
    int reads_sent      = 0;
    int scrolls_done    = 0;

    // idle pattern state, one per side: runs of gappy or back-to-back traffic
    int send_run    = 0;
    bit send_gappy  = 1'b0;
    int recv_run    = 0;
    bit recv_gappy  = 1'b0;

    function automatic int draw_wait(inout int run_left, inout bit gappy);
        if (run_left == 0) begin
            gappy    = ($urandom_range(0, 2) != 0);
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        return gappy ? int'($urandom_range(0, 13)) : 0;
    endfunction

    function automatic void scroll_if_past_end();
        if (cursor_model >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++) begin
                screen_model[i] = screen_model[i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++) begin
                screen_model[i] = BlankCell;
            end
            cursor_model -= COLS;
            scrolls_done++;
        end
    endfunction

    function automatic void store_cell(logic [DataW-1:0] cell_word);
        if (cursor_model < CELLS) begin
            screen_model[cursor_model] = cell_word;
        end
        cursor_model++;
        scroll_if_past_end();
    endfunction

    function automatic void put_char(logic [DataW-1:0] ca);
        logic [DataW-1:0] cell_word;
        cell_word = ca;
        if (cell_word[15:8] == 8'h00) begin
            cell_word[15:8] = DefaultAttr;
        end
        case (cell_word[7:0])
            ChBs: begin
                if (cursor_model > 0) begin
                    cursor_model--;
                    screen_model[cursor_model] = {cell_word[15:8], ChSpace};
                end
            end
            ChLf: begin
                cursor_model += COLS;
                cursor_model -= cursor_model % COLS;
                scroll_if_past_end();
            end
            ChCr: cursor_model -= cursor_model % COLS;
            // tab ignores the attribute and may scroll partway through
            ChTab: repeat (TabSpaces) store_cell(BlankCell);
            default: store_cell(cell_word);
        endcase
    endfunction

    function automatic screen_result_t predict_response(logic kind, logic [DataW-1:0] ca,
                                                        logic [IdxW-1:0] idx);
        screen_result_t r;
        r.data = '0;
        if (kind == ReqPut) begin
            put_char(ca);
        end else if (idx < CELLS) begin
            r.data = screen_model[idx];
        end
        r.cursor = IdxW'(cursor_model);
        return r;
    endfunction

    task automatic send_request(input logic kind, input logic [DataW-1:0] ca,
                                input logic [IdxW-1:0] idx);
        int gap;
        gap = draw_wait(send_run, send_gappy);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.char_attr  <= ca;
        req_ch.cell_index <= idx;
        do @(posedge clk); while (!req_ch.ready);
        expected_results.push_back(predict_response(kind, ca, idx));
        if (kind == ReqPut) puts_sent++;
        else reads_sent++;
    endtask

    task automatic send_put(input logic [DataW-1:0] ca);
        send_request(ReqPut, ca, IdxW'($urandom_range(0, MaxIdx)));
    endtask

    task automatic send_read(input int idx);
        send_request(ReqRead, DataW'($urandom), IdxW'(idx));
    endtask

    function automatic logic [7:0] rand_attr();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [DataW-1:0] rand_text_char();
        return {rand_attr(), 8'($urandom_range(8'h21, 8'h7e))};
    endfunction

    task automatic send_random_item();
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_put(rand_text_char());
        end else if (pick < 50) begin
            send_put(DataW'($urandom));
        end else if (pick < 58) begin
            send_put({rand_attr(), ChLf});
        end else if (pick < 62) begin
            send_put({rand_attr(), ChCr});
        end else if (pick < 67) begin
            send_put({rand_attr(), ChTab});
        end else if (pick < 74) begin
            send_put({rand_attr(), ChBs});
        end else if (pick < 87) begin
            // look near the cursor where the text is changing
            idx = cursor_model + int'($urandom_range(0, 2 * COLS)) - COLS;
            if (idx < 0) idx = 0;
            if (idx > MaxIdx) idx = MaxIdx;
            send_read(idx);
        end else begin
            send_read($urandom_range(0, MaxIdx));
        end
    endtask

    task automatic wait_for_all_results();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_put({8'h1e, ChBs});    // backspace at the top-left cell does nothing
        send_read(0);
        send_put(16'h0041);         // no attribute gets the default one
        send_put(16'hff7e);
        send_put(16'hffff);
        send_put(16'h0000);
        send_put(16'h8000);
        send_put({8'h4e, ChBs});
        send_put({8'h00, ChBs});
        for (int i = 0; i < 5; i++) send_read(i);
        send_put({8'h00, ChCr});
        send_put({8'h3c, ChLf});
        send_put({8'h00, ChTab});
        send_put({8'ha5, ChTab});
        send_read(COLS + 4);
        send_read(COLS + 9);
        send_read(CELLS - 1);
        send_read(CELLS);           // past the grid reads as zero
        send_read(MaxIdx);
        send_put({8'h00, ChSpace});
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_item();
    endtask

    task automatic test_pause_then_burst(input int count);
        wait_for_all_results();
        send_read(cursor_model);
        test_random_mix(count);
    endtask

    // bring the cursor to a few cells short of the end, then tab across the bottom edge
    task automatic test_scroll_corners();
        for (int short_by = 1; short_by <= TabSpaces; short_by++) begin
            while (cursor_model < CELLS - COLS) begin
                repeat ($urandom_range(0, 6)) send_put(rand_text_char());
                send_put({rand_attr(), ChLf});
            end
            send_put({rand_attr(), ChCr});
            while (cursor_model < CELLS - short_by) send_put(rand_text_char());
            send_put({rand_attr(), ChTab});
            repeat (3) send_read($urandom_range(CELLS - 2 * COLS, CELLS - 1));
            send_put({rand_attr(), ChBs});
            // newline scrolls when the cursor is still on the bottom row
            send_put({rand_attr(), ChLf});
            send_read($urandom_range(CELLS - 2 * COLS, CELLS - 1));
        end
        // plain character in the very last cell
        while (cursor_model != CELLS - 1) send_put(rand_text_char());
        send_put(rand_text_char());
        send_read(CELLS - COLS - 1);
        send_read(CELLS - 1);
    endtask

    task automatic check_response(input logic [IdxW-1:0] got_cursor,
                                  input logic [DataW-1:0] got_data);
        screen_result_t exp;
        if (expected_results.size() == 0) begin
            fault_count++;
            $display("response with nothing outstanding: cursor_pos %0d cell_data %h",
                     got_cursor, got_data);
        end else begin
            exp = expected_results.pop_front();
            if (got_cursor !== exp.cursor || got_data !== exp.data) begin
                if (mismatch_count < 10) begin
                    $display("mismatch on response %0d: cursor_pos exp %0d got %0d, %s",
                             results_checked, exp.cursor, got_cursor,
                             $sformatf("cell_data exp %h got %h", exp.data, got_data));
                end
                mismatch_count++;
            end
            results_checked++;
        end
    endtask

    // response side: random stalls, checks every accepted response
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(recv_run, recv_gappy);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            check_response(rsp_ch.cursor_pos, rsp_ch.cell_data);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= ReqPut;
        req_ch.char_attr  <= '0;
        req_ch.cell_index <= '0;
        for (int i = 0; i < CELLS; i++) screen_model[i] = BlankCell;
        cursor_model = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(400);
        test_pause_then_burst(250);
        test_scroll_corners();
        test_random_mix(500);

        wait_for_all_results();
        repeat (DrainTail) @(posedge clk);
        if (expected_results.size() != 0) fault_count++;

        $display("covered %0d put and %0d read requests with %0d scrolls, %0d responses checked",
                 puts_sent, reads_sent, scrolls_done, results_checked);
        $display("%0d field mismatches, %0d unexpected responses", mismatch_count, fault_count);
        if (mismatch_count == 0 && fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
